>>> rtl/mur_pkg.sv
// Shared types, constants and register indexes for the multi-sensor ultrasonic ranger.
`timescale 1ns / 1ps

package mur_pkg;

	// configuration register indexes
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_SLOT_LENGTH = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_TRIG_WIDTH  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ECHO_TIMEOUT = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_OOR_CODE    = 2'd3;

	localparam int SLOT_W    = 20;
	localparam int TRIG_W    = 8;
	localparam int ELAPSED_W = 16;
	localparam int DIST_W    = 16;
	localparam int CFG_DATA_W = SLOT_W;

	localparam logic [SLOT_W-1:0]    SLOT_LENGTH_RST  = 20'd70000;
	localparam logic [TRIG_W-1:0]    TRIG_WIDTH_RST   = 8'd10;
	localparam logic [ELAPSED_W-1:0] ECHO_TIMEOUT_RST = 16'd30000;
	localparam logic [DIST_W-1:0]    OOR_CODE_RST     = 16'hFFFF;
	localparam logic [DIST_W-1:0]    DIST_RST         = 16'hFFFF;

	// trigger slot pattern: front, left, front, right
	localparam int PATTERN_SLOTS = 4;
	localparam int STEP_W = $clog2(PATTERN_SLOTS);
	localparam int SENSOR_W = 2;
	localparam logic [SENSOR_W-1:0] SENSOR_FRONT = 2'd0;
	localparam logic [SENSOR_W-1:0] SENSOR_LEFT  = 2'd1;
	localparam logic [SENSOR_W-1:0] SENSOR_RIGHT = 2'd2;

	// d / 58 as (d * ceil(2^22 / 58)) >> 22, exact for d below 174762
	localparam int DIV58_SHIFT = 22;
	localparam int DIV58_MUL_W = 17;
	localparam logic [DIV58_MUL_W-1:0] DIV58_MUL = 17'd72316;
	localparam int DIV_PROD_W = ELAPSED_W + DIV58_MUL_W;
	localparam int QUOT_W = DIV_PROD_W - DIV58_SHIFT;

	typedef struct packed {
		logic [ELAPSED_W-1:0] timeout;
		logic [DIST_W-1:0]    oor_code;
	} echo_cfg_t;

	typedef struct packed {
		logic [DIST_W-1:0] dist_cm;
		logic              ready;
	} echo_stat_t;

	function automatic logic [SENSOR_W-1:0] slot_sensor(input logic [STEP_W-1:0] step);
		logic [SENSOR_W-1:0] s;
		case (step)
			2'd0: s = SENSOR_FRONT;
			2'd1: s = SENSOR_LEFT;
			2'd2: s = SENSOR_FRONT;
			2'd3: s = SENSOR_RIGHT;
			default: s = SENSOR_FRONT;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/mur_if.sv
// Valid/ready channel interfaces for the ranger's tick samples and results.
`timescale 1ns / 1ps

interface mur_sample_if;
	logic valid;
	logic ready;
	logic echo_front;
	logic echo_left;
	logic echo_right;
	logic clear_front;
	logic clear_left;
	logic clear_right;

	modport source (
		output valid, echo_front, echo_left, echo_right,
		output clear_front, clear_left, clear_right,
		input  ready
	);
	modport sink (
		input  valid, echo_front, echo_left, echo_right,
		input  clear_front, clear_left, clear_right,
		output ready
	);
endinterface

interface mur_result_if;
	logic        valid;
	logic        ready;
	logic        trig_front;
	logic        trig_left;
	logic        trig_right;
	logic [15:0] dist_front;
	logic [15:0] dist_left;
	logic [15:0] dist_right;
	logic        ready_front;
	logic        ready_left;
	logic        ready_right;

	modport source (
		output valid, trig_front, trig_left, trig_right,
		output dist_front, dist_left, dist_right,
		output ready_front, ready_left, ready_right,
		input  ready
	);
	modport sink (
		input  valid, trig_front, trig_left, trig_right,
		input  dist_front, dist_left, dist_right,
		input  ready_front, ready_left, ready_right,
		output ready
	);
endinterface

>>> rtl/mur_echo.sv
// One echo channel: edge detect, saturating duration count, distance and ready flag.
`timescale 1ns / 1ps

module mur_echo
	import mur_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       level,
	input  logic       clear,
	input  echo_cfg_t  cfg,
	output echo_stat_t stat
);

	logic                  prev_q;
	logic                  busy_q;
	logic [ELAPSED_W-1:0]  elapsed_q;
	logic [DIST_W-1:0]     dist_q;
	logic                  ready_q;

	logic [ELAPSED_W-1:0]  elapsed_inc;
	logic                  fall;
	logic                  rise;
	logic                  done;
	logic [DIV_PROD_W-1:0] prod;
	logic [QUOT_W-1:0]     quot;
	logic                  in_range;
	logic [DIST_W-1:0]     dist_new;

	always_comb begin
		elapsed_inc = (busy_q && elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
		fall = prev_q & ~level;
		rise = ~prev_q & level;
		done = fall & busy_q;
		prod = DIV_PROD_W'(elapsed_inc) * DIV_PROD_W'(DIV58_MUL);
		quot = prod[DIV_PROD_W-1:DIV58_SHIFT];
		in_range = (elapsed_inc != '0) && (elapsed_inc < cfg.timeout);
		if (done) begin
			dist_new = in_range ? DIST_W'(quot) : cfg.oor_code;
		end else begin
			dist_new = dist_q;
		end
	end

	// flag seen by the result is taken before this tick's clear
	assign stat.dist_cm = dist_new;
	assign stat.ready   = ready_q | done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= 1'b0;
			busy_q    <= 1'b0;
			elapsed_q <= '0;
			dist_q    <= DIST_RST;
			ready_q   <= 1'b0;
		end else if (step) begin
			prev_q    <= level;
			busy_q    <= done ? 1'b0 : (rise ? 1'b1 : busy_q);
			elapsed_q <= rise ? '0 : elapsed_inc;
			dist_q    <= dist_new;
			// a completion wins over a clear in the same tick
			ready_q   <= done | (ready_q & ~clear);
		end
	end

endmodule

>>> rtl/multi_ultrasonic_ranger.sv
// Top level of the three-sensor ultrasonic ranger: trigger sequencer, echo channels, result register.
`timescale 1ns / 1ps

// Each sample transfer is one microsecond tick carrying the three echo levels and the
// ready-clear strobes; each tick produces exactly one result with the trigger levels,
// the last stored distance per sensor (centimetres, or the out-of-range code) and the
// ready flags as they stand before that tick's clears. A tick is taken every clock
// cycle: all state updates at the sample transfer and the result sits in a single
// output register, so sample ready is low only while that register holds a result
// that the sink is not taking. Triggers fire in slot order front, left, front, right,
// one slot every slot_length_us ticks, each high for trig_width_us ticks. The user
// makes configuration writes (cfg_we/cfg_index/cfg_data) while no tick is in flight;
// not enforced by the block. Indexes: 0 slot length, 1 trigger width, 2 echo timeout, 3 out-of-range code.

module multi_ultrasonic_ranger
	import mur_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mur_sample_if.sink            sample,
	mur_result_if.source          result
);

	typedef struct packed {
		logic [2:0]        trig;
		logic [DIST_W-1:0] dist_front;
		logic [DIST_W-1:0] dist_left;
		logic [DIST_W-1:0] dist_right;
		logic [2:0]        ready;
	} res_t;

	logic [SLOT_W-1:0]    slot_length_q;
	logic [TRIG_W-1:0]    trig_width_q;
	echo_cfg_t            echo_cfg_q;

	logic [SLOT_W-1:0]    slot_timer_q;
	logic [STEP_W-1:0]    pattern_step_q;
	logic [TRIG_W-1:0]    pulse_timer_q;
	logic [SENSOR_W-1:0]  pulse_sensor_q;

	logic                 out_valid_q;
	res_t                 res_q;

	logic                 accept;
	logic [SLOT_W-1:0]    slot_inc;
	logic                 fire;
	logic [SLOT_W-1:0]    slot_next;
	logic [TRIG_W-1:0]    pulse_next;
	logic [SENSOR_W-1:0]  sensor_next;
	logic [STEP_W-1:0]    step_next;
	logic [2:0]           trig_next;
	echo_stat_t           stat_front;
	echo_stat_t           stat_left;
	echo_stat_t           stat_right;

	assign sample.ready = !out_valid_q || result.ready;
	assign accept = sample.valid && sample.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_length_q       <= SLOT_LENGTH_RST;
			trig_width_q        <= TRIG_WIDTH_RST;
			echo_cfg_q.timeout  <= ECHO_TIMEOUT_RST;
			echo_cfg_q.oor_code <= OOR_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLOT_LENGTH:  slot_length_q       <= cfg_data;
				REG_TRIG_WIDTH:   trig_width_q        <= cfg_data[TRIG_W-1:0];
				REG_ECHO_TIMEOUT: echo_cfg_q.timeout  <= cfg_data[ELAPSED_W-1:0];
				REG_OOR_CODE:     echo_cfg_q.oor_code <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// slot sequencer and trigger pulse
	always_comb begin
		slot_inc = slot_timer_q + 1'b1;
		fire = (slot_inc >= slot_length_q);
		slot_next = fire ? '0 : slot_inc;
		if (fire) begin
			pulse_next  = trig_width_q;
			sensor_next = slot_sensor(pattern_step_q);
			step_next   = pattern_step_q + 1'b1;
		end else begin
			pulse_next  = (pulse_timer_q != '0) ? pulse_timer_q - 1'b1 : pulse_timer_q;
			sensor_next = pulse_sensor_q;
			step_next   = pattern_step_q;
		end
		trig_next[0] = (pulse_next != '0) && (sensor_next == SENSOR_FRONT);
		trig_next[1] = (pulse_next != '0) && (sensor_next == SENSOR_LEFT);
		trig_next[2] = (pulse_next != '0) && (sensor_next == SENSOR_RIGHT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_timer_q   <= '0;
			pattern_step_q <= '0;
			pulse_timer_q  <= '0;
			pulse_sensor_q <= SENSOR_FRONT;
		end else if (accept) begin
			slot_timer_q   <= slot_next;
			pattern_step_q <= step_next;
			pulse_timer_q  <= pulse_next;
			pulse_sensor_q <= sensor_next;
		end
	end

	mur_echo u_echo_front (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.level  (sample.echo_front),
		.clear  (sample.clear_front),
		.cfg    (echo_cfg_q),
		.stat   (stat_front)
	);

	mur_echo u_echo_left (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.level  (sample.echo_left),
		.clear  (sample.clear_left),
		.cfg    (echo_cfg_q),
		.stat   (stat_left)
	);

	mur_echo u_echo_right (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.level  (sample.echo_right),
		.clear  (sample.clear_right),
		.cfg    (echo_cfg_q),
		.stat   (stat_right)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.trig       <= trig_next;
			res_q.dist_front <= stat_front.dist_cm;
			res_q.dist_left  <= stat_left.dist_cm;
			res_q.dist_right <= stat_right.dist_cm;
			res_q.ready      <= {stat_right.ready, stat_left.ready, stat_front.ready};
		end
	end

	assign result.valid       = out_valid_q;
	assign result.trig_front  = res_q.trig[0];
	assign result.trig_left   = res_q.trig[1];
	assign result.trig_right  = res_q.trig[2];
	assign result.dist_front  = res_q.dist_front;
	assign result.dist_left   = res_q.dist_left;
	assign result.dist_right  = res_q.dist_right;
	assign result.ready_front = res_q.ready[0];
	assign result.ready_left  = res_q.ready[1];
	assign result.ready_right = res_q.ready[2];

`ifndef SYNTH
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result.valid)
		else $error("sample transfer did not produce a result");

	a_one_trigger: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> $onehot0({result.trig_front, result.trig_left, result.trig_right}))
		else $error("more than one trigger high");

	a_seq_holds_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ($stable(slot_timer_q) && $stable(pulse_timer_q)
			&& $stable(pattern_step_q)))
		else $error("sequencer moved without a sample transfer");

	a_no_trig_zero_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pulse_next == '0) |=> (res_q.trig == 3'b000))
		else $error("trigger high with expired pulse timer");
`endif

endmodule
